>>> design/aes_pkg.sv
`timescale 1ns / 1ps
package aes_pkg;
    localparam int ROUNDS_DEF = 10;
    localparam int KEY_W = 64;
    localparam int BLK_W = 64;
    localparam int WORD_W = 32;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_UPPER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOWER = 1'b1;
    localparam logic CMD_ENC = 1'b0;
    localparam logic CMD_DEC = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE, ST_EXPAND, ST_LOAD, ST_ROUND, ST_DONE
    } t_state;

    localparam logic [7:0] SBOX [256] = '{
 8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
 8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
 8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
 8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
 8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
 8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
 8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
 8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
 8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
 8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
 8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
 8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
 8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
 8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
 8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
 8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] inv_sbox(input logic [7:0] v);
        logic [7:0] r;
        r = '0;
        for (int i = 0; i < 256; i++) begin
            if (SBOX[i] == v) r = 8'(i);
        end
        return r;
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] rcon(input logic [3:0] r);
        logic [7:0] v;
        v = 8'h01;
        for (int i = 1; i < 10; i++) begin
            if (4'(i) <= r - 4'd1) v = xt(v);
        end
        return v;
    endfunction
endpackage

>>> design/aes128_block_cipher_unit.sv
`timescale 1ns / 1ps
// AES-128 encrypt/decrypt core. A key write on the configuration channel
// (index 0: key bytes 0..7, index 1: bytes 8..15) starts a schedule expansion
// that writes the 44 round-key words into a single-port-write RAM, one word a
// cycle (the channel and the input are held off meanwhile, and a block is
// never taken in the same cycle as a key write). A block on the slave stream
// (tuser = command, 0 encrypt, 1 decrypt) gives its result on the master
// stream after a load state, then the rounds, each collecting its four key
// words from the round-key RAM, which delivers one 32-bit word a cycle, and
// applying the round on the last one, then a move of the result into the
// output register. The next block can be taken in the cycle after that move,
// so a new block is taken only once the previous one has left the rounds. The
// output register holds the result until taken; a new block may start while it
// waits, and only the final move stalls if the previous result is still unread.
// Use of the cipher before any key write gives undefined results.
module aes128_block_cipher_unit #(
    parameter int ROUNDS = aes_pkg::ROUNDS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [aes_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [aes_pkg::KEY_W-1:0]     i_cfg_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [127:0]                  s_axis_tdata,  // block_lower, block_upper
    input  logic                          s_axis_tuser,  // cmd
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [127:0]                  m_axis_tdata   // out_lower, out_upper
);
    import aes_pkg::*;

    localparam int NW = 4 * (ROUNDS + 1);
    localparam int AW = $clog2(NW);
    localparam int RW = $clog2(ROUNDS + 1);

    t_state r_state, n_state;
    logic [KEY_W-1:0] r_key_up, r_key_lo;
    logic [AW-1:0] r_cnt;          // expansion word index
    logic [1:0] r_col;             // key column read this cycle
    logic [RW-1:0] r_rnd;          // rounds applied so far
    logic r_cmd;
    logic [127:0] r_st, n_st;      // state, byte 0 in bits 127:120
    logic [95:0] r_kw;             // key words 0..2 of the current round
    logic [127:0] r_win;           // last four schedule words (expansion)
    logic [127:0] r_out;
    logic r_oval;

    logic ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [WORD_W-1:0] ram_wdata, ram_rdata;
    logic out_load;                // move the finished block into the output register

    aes_ram #(.WIDTH(WORD_W), .DEPTH(NW)) u_rk (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(ram_waddr), .i_wdata(ram_wdata),
        .i_raddr(ram_raddr), .o_rdata(ram_rdata)
    );

    // schedule word: next word from the window
    logic [WORD_W-1:0] exp_t, exp_w;
    always_comb begin
        exp_t = r_win[31:0];
        if (r_cnt[1:0] == 2'd0) begin
            exp_t = {SBOX[r_win[23:16]], SBOX[r_win[15:8]], SBOX[r_win[7:0]],
                     SBOX[r_win[31:24]]} ^ {rcon(4'(r_cnt >> 2)), 24'h0};
        end
        exp_w = r_win[127:96] ^ exp_t;
    end

    assign o_cfg_ready = (r_state == ST_IDLE);
    assign s_axis_tready = (r_state == ST_IDLE) && !i_cfg_valid;
    assign m_axis_tvalid = r_oval;
    assign m_axis_tdata = r_out;
    assign out_load = (r_state == ST_DONE) && (!r_oval || m_axis_tready);

    // read word address: encrypt walks forward, decrypt by rounds backward;
    // once a round is applied, fetch the first word of the next one
    logic [RW-1:0] rd_round, rd_idx;
    always_comb begin
        rd_idx = r_rnd + RW'((r_state == ST_ROUND) && (r_col == 2'd0));
        rd_round = (r_cmd == CMD_DEC) ? RW'(ROUNDS) - rd_idx : rd_idx;
        ram_raddr = AW'({rd_round, 2'b00}) | AW'(r_col);
        ram_we = (r_state == ST_EXPAND);
        ram_waddr = (r_state == ST_EXPAND) ? r_cnt : AW'(0);
        ram_wdata = (r_cnt < AW'(4)) ? r_win[127:96] : exp_w;
    end

    // round function
    logic [127:0] key, sb, sr, mc, res;
    logic [7:0] a0, a1, a2, a3, x2, x4, x8;
    logic last;
    always_comb begin
        key = {r_kw, ram_rdata};
        last = (r_rnd == RW'(ROUNDS));
        sb = '0; sr = '0; mc = '0;
        a0 = '0; a1 = '0; a2 = '0; a3 = '0;
        x2 = '0; x4 = '0; x8 = '0;
        if (r_rnd == '0) begin
            res = r_st ^ key;
        end else if (r_cmd == CMD_ENC) begin
            for (int i = 0; i < 16; i++) sb[127-8*i -: 8] = SBOX[r_st[127-8*i -: 8]];
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    sr[127-8*(r+4*c) -: 8] = sb[127-8*(r+4*((c+r)%4)) -: 8];
            for (int c = 0; c < 4; c++) begin
                a0 = sr[127-32*c -: 8]; a1 = sr[119-32*c -: 8];
                a2 = sr[111-32*c -: 8]; a3 = sr[103-32*c -: 8];
                mc[127-32*c -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
                mc[119-32*c -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
                mc[111-32*c -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
                mc[103-32*c -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
            end
            res = (last ? sr : mc) ^ key;
        end else begin
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    sr[127-8*(r+4*c) -: 8] = r_st[127-8*(r+4*((c+4-r)%4)) -: 8];
            for (int i = 0; i < 16; i++) sb[127-8*i -: 8] = inv_sbox(sr[127-8*i -: 8]);
            sb = sb ^ key;
            for (int c = 0; c < 4; c++) begin
                for (int r = 0; r < 4; r++) begin
                    a0 = '0;
                    for (int k = 0; k < 4; k++) begin
                        a1 = sb[127-8*(k+4*c) -: 8];
                        x2 = xt(a1); x4 = xt(x2); x8 = xt(x4);
                        unique case ((k - r + 4) % 4)
                            0: a0 = a0 ^ x8 ^ x4 ^ x2;
                            1: a0 = a0 ^ x8 ^ x2 ^ a1;
                            2: a0 = a0 ^ x8 ^ x4 ^ a1;
                            default: a0 = a0 ^ x8 ^ a1;
                        endcase
                    end
                    mc[127-8*(r+4*c) -: 8] = a0;
                end
            end
            res = last ? sb : mc;
        end
        n_st = res;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cfg_valid && i_cfg_index <= REG_KEY_LOWER) n_state = ST_EXPAND;
                else if (s_axis_tvalid && s_axis_tready) n_state = ST_LOAD;
            end
            ST_EXPAND: if (r_cnt == AW'(NW - 1)) n_state = ST_IDLE;
            ST_LOAD:   n_state = ST_ROUND;
            ST_ROUND:  if (r_col == 2'd0 && r_rnd == RW'(ROUNDS)) n_state = ST_DONE;
            ST_DONE:   if (out_load) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_oval <= 1'b0;
            r_key_up <= '0;
            r_key_lo <= '0;
        end else begin
            r_state <= n_state;
            if (out_load) r_oval <= 1'b1;
            else if (m_axis_tvalid && m_axis_tready) r_oval <= 1'b0;
            if (r_state == ST_IDLE && i_cfg_valid) begin
                if (i_cfg_index == REG_KEY_UPPER) r_key_up <= i_cfg_data;
                if (i_cfg_index == REG_KEY_LOWER) r_key_lo <= i_cfg_data;
            end
        end
    end

    // datapath
    logic [127:0] new_key;
    assign new_key = (i_cfg_index == REG_KEY_UPPER) ? {i_cfg_data, r_key_lo}
                                                   : {r_key_up, i_cfg_data};
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_col <= 2'd0;
                r_rnd <= '0;
                if (i_cfg_valid) begin
                    // seed window; words 0..3 go in while the window shifts
                    r_win <= new_key;
                    r_cnt <= AW'(0);
                end else begin
                    // block_upper sits in the low half of tdata
                    r_st <= {s_axis_tdata[63:0], s_axis_tdata[127:64]};
                    r_cmd <= s_axis_tuser;
                end
            end
            ST_EXPAND: begin
                r_cnt <= r_cnt + AW'(1);
                if (r_cnt < AW'(4)) begin
                    r_win <= {r_win[95:0], r_win[127:96]};
                end else begin
                    r_win <= {r_win[95:0], exp_w};
                end
            end
            ST_LOAD: r_col <= 2'd1;
            ST_ROUND: begin
                r_kw <= {r_kw[63:0], ram_rdata};
                r_col <= r_col + 2'd1;
                if (r_col == 2'd0) begin
                    r_st <= n_st;
                    r_rnd <= r_rnd + RW'(1);
                end
            end
            ST_DONE: if (out_load) r_out <= {r_st[63:0], r_st[127:64]};
            default: ;
        endcase
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata));
    a_one_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && i_cfg_valid));
    a_busy_refuse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_cfg_ready && !s_axis_tready);
    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND) |-> (r_rnd <= RW'(ROUNDS)));
endmodule

>>> design/aes_ram.sv
`timescale 1ns / 1ps
module aes_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 44
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule
